>>> design/fls_pkg.sv
`timescale 1ns / 1ps
package fls_pkg;

	// block geometry
	localparam int ROWS     = 8;
	localparam int ROW_W    = 16;
	localparam int ROUNDS   = 12;
	localparam int HALF_W   = 64;
	localparam int CFG_IDX_W = 1;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [ROWS-1:0][ROW_W-1:0] block_t;

	// command codes
	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// key register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

	// round constants
	localparam row_t RC [0:ROUNDS-1] = '{
		16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7,
		16'h9058, 16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F
	};

	// l-box nibble tables, nibble 0 is bits 3..0
	localparam row_t LBOX_FWD [0:3][0:15] = '{
		'{16'h0000, 16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7, 16'h9058,
		  16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F, 16'h2B80, 16'hFAEF, 16'h4510},
		'{16'h0000, 16'h5296, 16'hD183, 16'h8315, 16'hC2B1, 16'h9027, 16'h1332, 16'h41A4,
		  16'h496C, 16'h1BFA, 16'h98EF, 16'hCA79, 16'h8BDD, 16'hD94B, 16'h5A5E, 16'h08C8},
		'{16'h0000, 16'h74C2, 16'hD324, 16'hA7E6, 16'hCE28, 16'hBAEA, 16'h1D0C, 16'h69CE,
		  16'h6856, 16'h1C94, 16'hBB72, 16'hCFB0, 16'hA67E, 16'hD2BC, 16'h755A, 16'h0198},
		'{16'h0000, 16'hE489, 16'h6839, 16'h8CB0, 16'h5E44, 16'hBACD, 16'h367D, 16'hD2F4,
		  16'h614B, 16'h85C2, 16'h0972, 16'hEDFB, 16'h3F0F, 16'hDB86, 16'h5736, 16'hB3BF}
	};

	localparam row_t LBOX_INV [0:3][0:15] = '{
		'{16'h0000, 16'hB065, 16'h8935, 16'h3950, 16'h4A95, 16'hFAF0, 16'hC3A0, 16'h73C5,
		  16'hB489, 16'h04EC, 16'h3DBC, 16'h8DD9, 16'hFE1C, 16'h4E79, 16'h7729, 16'hC74C},
		'{16'h0000, 16'h2857, 16'h26C5, 16'h0E92, 16'hC989, 16'hE1DE, 16'hEF4C, 16'hC71B,
		  16'h1173, 16'h3924, 16'h37B6, 16'h1FE1, 16'hD8FA, 16'hF0AD, 16'hFE3F, 16'hD668},
		'{16'h0000, 16'h82AD, 16'h4653, 16'hC4FE, 16'h550B, 16'hD7A6, 16'h1358, 16'h91F5,
		  16'h6C83, 16'hEE2E, 16'h2AD0, 16'hA87D, 16'h3988, 16'hBB25, 16'h7FDB, 16'hFD76},
		'{16'h0000, 16'h4339, 16'hB903, 16'hFA3A, 16'hFFFE, 16'hBCC7, 16'h46FD, 16'h05C4,
		  16'h1669, 16'h5550, 16'hAF6A, 16'hEC53, 16'hE997, 16'hAAAE, 16'h5094, 16'h13AD}
	};

	// l-box on one row: xor of four nibble lookups
	function automatic row_t lbox_row(row_t w, logic inv);
		row_t f;
		row_t r;
		begin
			f = LBOX_FWD[0][w[3:0]] ^ LBOX_FWD[1][w[7:4]] ^
			    LBOX_FWD[2][w[11:8]] ^ LBOX_FWD[3][w[15:12]];
			r = LBOX_INV[0][w[3:0]] ^ LBOX_INV[1][w[7:4]] ^
			    LBOX_INV[2][w[11:8]] ^ LBOX_INV[3][w[15:12]];
			return inv ? r : f;
		end
	endfunction

	// bitsliced 5-bit misty box on rows 0..4
	function automatic block_t s5_fwd(block_t x);
		block_t y;
		begin
			y = x;
			y[2] = y[2] ^ (y[0] & y[1]);
			y[1] = y[1] ^ y[2];
			y[3] = y[3] ^ (y[0] & y[4]);
			y[2] = y[2] ^ y[3];
			y[0] = y[0] ^ (y[1] & y[3]);
			y[4] = y[4] ^ y[1];
			y[1] = y[1] ^ (y[2] & y[4]);
			y[1] = y[1] ^ y[0];
			return y;
		end
	endfunction

	function automatic block_t s5_inv(block_t x);
		block_t y;
		begin
			y = x;
			y[1] = y[1] ^ y[0];
			y[1] = y[1] ^ (y[2] & y[4]);
			y[4] = y[4] ^ y[1];
			y[0] = y[0] ^ (y[1] & y[3]);
			y[2] = y[2] ^ y[3];
			y[3] = y[3] ^ (y[0] & y[4]);
			y[1] = y[1] ^ y[2];
			y[2] = y[2] ^ (y[0] & y[1]);
			return y;
		end
	endfunction

	// 3-bit chi on rows 5..7, an involution
	function automatic block_t chi3(block_t x);
		block_t y;
		begin
			y = x;
			y[5] = x[5] ^ (~x[6] & x[7]);
			y[6] = x[6] ^ (~x[7] & x[5]);
			y[7] = x[7] ^ (~x[5] & x[6]);
			return y;
		end
	endfunction

	function automatic block_t sbox_fwd(block_t x);
		block_t y;
		begin
			y = s5_fwd(x);
			y[0] = y[0] ^ y[5];
			y[1] = y[1] ^ y[6];
			y[2] = y[2] ^ y[7];
			y[3] = ~y[3];
			y[4] = ~y[4];
			y = chi3(y);
			y[5] = y[5] ^ y[0];
			y[6] = y[6] ^ y[1];
			y[7] = y[7] ^ y[2];
			return s5_fwd(y);
		end
	endfunction

	function automatic block_t sbox_inv(block_t x);
		block_t y;
		begin
			y = s5_inv(x);
			y[5] = y[5] ^ y[0];
			y[6] = y[6] ^ y[1];
			y[7] = y[7] ^ y[2];
			y = chi3(y);
			y[3] = ~y[3];
			y[4] = ~y[4];
			y[0] = y[0] ^ y[5];
			y[1] = y[1] ^ y[6];
			y[2] = y[2] ^ y[7];
			return s5_inv(y);
		end
	endfunction

endpackage

>>> design/fls_round.sv
`timescale 1ns / 1ps
module fls_round (
	input  fls_pkg::block_t x,
	input  logic            cmd,
	input  fls_pkg::block_t key,
	input  fls_pkg::row_t   rc,
	output fls_pkg::block_t y
);
	import fls_pkg::*;

	block_t enc_a;
	block_t enc_b;
	block_t enc_y;
	block_t dec_a;
	block_t dec_b;
	block_t dec_y;

	// forward round: constant, s-layer, l-box, key
	always_comb begin
		enc_a = x;
		enc_a[0] = x[0] ^ rc;
		enc_b = sbox_fwd(enc_a);
		for (int r = 0; r < ROWS; r++) begin
			enc_y[r] = lbox_row(enc_b[r], 1'b0) ^ key[r];
		end
	end

	// inverse round: key, inverse l-box, inverse s-layer, constant
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			dec_a[r] = lbox_row(x[r] ^ key[r], 1'b1);
		end
		dec_b = sbox_inv(dec_a);
		dec_y = dec_b;
		dec_y[0] = dec_b[0] ^ rc;
	end

	assign y = (cmd == CMD_DEC) ? dec_y : enc_y;

endmodule

>>> design/bitsliced_ls_block_cipher.sv
`timescale 1ns / 1ps
// the start strobe and block pass through the round stages in order to done, one round per stage
// throughput: one item per cycle, busy is never raised
// the twelve unrolled round stages are fully pipelined; nothing upstream of done can stall
// reset clears the stage valid bits and both key registers to zero
// results appear for exactly one cycle with done high
module bitsliced_ls_block_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [fls_pkg::HALF_W-1:0]     block_low,
	input  logic [fls_pkg::HALF_W-1:0]     block_high,
	output logic                           done,
	output logic [fls_pkg::HALF_W-1:0]     result_low,
	output logic [fls_pkg::HALF_W-1:0]     result_high,
	input  logic                           cfg_we,
	input  logic [fls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fls_pkg::HALF_W-1:0]     cfg_data
);
	import fls_pkg::*;

	logic [HALF_W-1:0] key_low_q;
	logic [HALF_W-1:0] key_high_q;
	block_t            key;
	block_t            blk_in;

	block_t            blk_s  [ROUNDS];
	logic              cmd_s  [ROUNDS];
	logic              vld_s  [ROUNDS];
	block_t            rnd_x  [ROUNDS];
	block_t            rnd_y  [ROUNDS];
	logic              rnd_c  [ROUNDS];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key    = {key_high_q, key_low_q};
	assign busy   = 1'b0;
	// whitening key goes in ahead of the first forward round
	assign blk_in = (command == CMD_ENC) ? ({block_high, block_low} ^ key)
	                                     : {block_high, block_low};

	// twelve round stages
	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		if (g == 0) begin : g_first
			assign rnd_x[g] = blk_in;
			assign rnd_c[g] = command;
		end else begin : g_next
			assign rnd_x[g] = blk_s[g-1];
			assign rnd_c[g] = cmd_s[g-1];
		end

		fls_round u_round (
			.x   (rnd_x[g]),
			.cmd (rnd_c[g]),
			.key (key),
			.rc  ((rnd_c[g] == CMD_DEC) ? RC[ROUNDS-1-g] : RC[g]),
			.y   (rnd_y[g])
		);

		// valid bit per stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= (g == 0) ? start : vld_s[g-1 < 0 ? 0 : g-1];
			end
		end

		// payload, last stage adds the closing key on the inverse path
		always_ff @(posedge clk) begin
			cmd_s[g] <= rnd_c[g];
			if (g == ROUNDS-1 && rnd_c[g] == CMD_DEC) begin
				blk_s[g] <= rnd_y[g] ^ key;
			end else begin
				blk_s[g] <= rnd_y[g];
			end
		end
	end

	assign done        = vld_s[ROUNDS-1];
	assign result_low  = blk_s[ROUNDS-1][3:0];
	assign result_high = blk_s[ROUNDS-1][7:4];

	// every accepted item comes out after the full pipe depth
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##12 done)
		else $error("item lost in round pipeline");

	// no strobe without an item entered at the head of the pipe
	a_no_extra : assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##12 !done)
		else $error("spurious result strobe");

	// the stage ahead of the output carries the item in the cycle before
	a_stage_order : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ROUNDS-2] |=> done)
		else $error("valid bit dropped at last stage");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef logic [7:0][15:0] slab_t;

	// directed probe: with echo set, the block sent is the previous result and
	// lo/hi hold the value that must come back
	typedef struct packed {
		logic        cmd;
		logic        echo;
		logic [63:0] lo;
		logic [63:0] hi;
	} probe_t;

	localparam int N_PROBES = 16;
	localparam int N_PHASES = 7;
	localparam int PHASE_ITEMS = 250;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] ALT_5 = 64'h5555_5555_5555_5555;

	localparam probe_t PROBES [N_PROBES] = '{
		'{fls_pkg::CMD_ENC, 1'b0, 64'h0, 64'h0},
		'{fls_pkg::CMD_DEC, 1'b1, 64'h0, 64'h0},
		'{fls_pkg::CMD_ENC, 1'b0, ONES, ONES},
		'{fls_pkg::CMD_DEC, 1'b1, ONES, ONES},
		'{fls_pkg::CMD_DEC, 1'b0, 64'h0, 64'h0},
		'{fls_pkg::CMD_ENC, 1'b1, 64'h0, 64'h0},
		'{fls_pkg::CMD_DEC, 1'b0, ONES, ONES},
		'{fls_pkg::CMD_ENC, 1'b1, ONES, ONES},
		'{fls_pkg::CMD_ENC, 1'b0, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
		'{fls_pkg::CMD_DEC, 1'b1, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
		'{fls_pkg::CMD_ENC, 1'b0, ALT_A, ALT_5},
		'{fls_pkg::CMD_DEC, 1'b0, ALT_5, ALT_A},
		'{fls_pkg::CMD_ENC, 1'b1, ALT_5, ALT_A},
		'{fls_pkg::CMD_ENC, 1'b0, 64'h0000_0000_0000_FFFF, 64'h0},
		'{fls_pkg::CMD_ENC, 1'b0, 64'h0, 64'hFFFF_0000_0000_0000},
		'{fls_pkg::CMD_DEC, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}
	};

	// round constants, first round first
	localparam logic [15:0] MIX_RC [12] = '{
		16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7,
		16'h9058, 16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F
	};

	// row diffusion tables, one per nibble position
	localparam logic [15:0] DIFF_FWD [4][16] = '{
		'{16'h0000, 16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7, 16'h9058,
		  16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F, 16'h2B80, 16'hFAEF, 16'h4510},
		'{16'h0000, 16'h5296, 16'hD183, 16'h8315, 16'hC2B1, 16'h9027, 16'h1332, 16'h41A4,
		  16'h496C, 16'h1BFA, 16'h98EF, 16'hCA79, 16'h8BDD, 16'hD94B, 16'h5A5E, 16'h08C8},
		'{16'h0000, 16'h74C2, 16'hD324, 16'hA7E6, 16'hCE28, 16'hBAEA, 16'h1D0C, 16'h69CE,
		  16'h6856, 16'h1C94, 16'hBB72, 16'hCFB0, 16'hA67E, 16'hD2BC, 16'h755A, 16'h0198},
		'{16'h0000, 16'hE489, 16'h6839, 16'h8CB0, 16'h5E44, 16'hBACD, 16'h367D, 16'hD2F4,
		  16'h614B, 16'h85C2, 16'h0972, 16'hEDFB, 16'h3F0F, 16'hDB86, 16'h5736, 16'hB3BF}
	};

	localparam logic [15:0] DIFF_INV [4][16] = '{
		'{16'h0000, 16'hB065, 16'h8935, 16'h3950, 16'h4A95, 16'hFAF0, 16'hC3A0, 16'h73C5,
		  16'hB489, 16'h04EC, 16'h3DBC, 16'h8DD9, 16'hFE1C, 16'h4E79, 16'h7729, 16'hC74C},
		'{16'h0000, 16'h2857, 16'h26C5, 16'h0E92, 16'hC989, 16'hE1DE, 16'hEF4C, 16'hC71B,
		  16'h1173, 16'h3924, 16'h37B6, 16'h1FE1, 16'hD8FA, 16'hF0AD, 16'hFE3F, 16'hD668},
		'{16'h0000, 16'h82AD, 16'h4653, 16'hC4FE, 16'h550B, 16'hD7A6, 16'h1358, 16'h91F5,
		  16'h6C83, 16'hEE2E, 16'h2AD0, 16'hA87D, 16'h3988, 16'hBB25, 16'h7FDB, 16'hFD76},
		'{16'h0000, 16'h4339, 16'hB903, 16'hFA3A, 16'hFFFE, 16'hBCC7, 16'h46FD, 16'h05C4,
		  16'h1669, 16'h5550, 16'hAF6A, 16'hEC53, 16'hE997, 16'hAAAE, 16'h5094, 16'h13AD}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic command;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic done;
	logic [63:0] result_low;
	logic [63:0] result_high;
	logic cfg_we;
	logic [fls_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	// predictor copy of the key registers
	logic [63:0] cur_key_lo;
	logic [63:0] cur_key_hi;

	logic [127:0] pending_blocks [$];
	logic [63:0] last_lo;
	logic [63:0] last_hi;
	int errors = 0;
	int blocks_sent = 0;
	int blocks_checked = 0;
	int key_settings = 1;

	bitsliced_ls_block_cipher uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.block_low(block_low),
		.block_high(block_high),
		.done(done),
		.result_low(result_low),
		.result_high(result_high),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// row diffusion: xor of four nibble lookups
	function automatic logic [15:0] diffuse(logic [15:0] w, logic inv);
		if (inv) begin
			return DIFF_INV[0][w[3:0]] ^ DIFF_INV[1][w[7:4]] ^
			       DIFF_INV[2][w[11:8]] ^ DIFF_INV[3][w[15:12]];
		end
		return DIFF_FWD[0][w[3:0]] ^ DIFF_FWD[1][w[7:4]] ^
		       DIFF_FWD[2][w[11:8]] ^ DIFF_FWD[3][w[15:12]];
	endfunction

	// five-bit misty box on rows 0..4
	function automatic slab_t misty5(slab_t x);
		x[2] = x[2] ^ (x[0] & x[1]);
		x[1] = x[1] ^ x[2];
		x[3] = x[3] ^ (x[0] & x[4]);
		x[2] = x[2] ^ x[3];
		x[0] = x[0] ^ (x[1] & x[3]);
		x[4] = x[4] ^ x[1];
		x[1] = x[1] ^ (x[2] & x[4]);
		x[1] = x[1] ^ x[0];
		return x;
	endfunction

	function automatic slab_t misty5_undo(slab_t x);
		x[1] = x[1] ^ x[0];
		x[1] = x[1] ^ (x[2] & x[4]);
		x[4] = x[4] ^ x[1];
		x[0] = x[0] ^ (x[1] & x[3]);
		x[2] = x[2] ^ x[3];
		x[3] = x[3] ^ (x[0] & x[4]);
		x[1] = x[1] ^ x[2];
		x[2] = x[2] ^ (x[0] & x[1]);
		return x;
	endfunction

	// three-bit chi on rows 5..7, self-inverse
	function automatic slab_t chi_upper(slab_t x);
		slab_t y;
		y = x;
		y[5] = x[5] ^ (~x[6] & x[7]);
		y[6] = x[6] ^ (~x[7] & x[5]);
		y[7] = x[7] ^ (~x[5] & x[6]);
		return y;
	endfunction

	function automatic slab_t column_sub(slab_t x);
		x = misty5(x);
		x[0] = x[0] ^ x[5];
		x[1] = x[1] ^ x[6];
		x[2] = x[2] ^ x[7];
		x[3] = ~x[3];
		x[4] = ~x[4];
		x = chi_upper(x);
		x[5] = x[5] ^ x[0];
		x[6] = x[6] ^ x[1];
		x[7] = x[7] ^ x[2];
		return misty5(x);
	endfunction

	function automatic slab_t column_unsub(slab_t x);
		x = misty5_undo(x);
		x[5] = x[5] ^ x[0];
		x[6] = x[6] ^ x[1];
		x[7] = x[7] ^ x[2];
		x = chi_upper(x);
		x[3] = ~x[3];
		x[4] = ~x[4];
		x[0] = x[0] ^ x[5];
		x[1] = x[1] ^ x[6];
		x[2] = x[2] ^ x[7];
		return misty5_undo(x);
	endfunction

	// full 12-round pass under the current key, result packed as {high, low}
	function automatic logic [127:0] ls_crypt(logic cmd, logic [63:0] lo, logic [63:0] hi);
		slab_t x;
		slab_t k;
		x = {hi, lo};
		k = {cur_key_hi, cur_key_lo};
		if (cmd == fls_pkg::CMD_ENC) begin
			x = x ^ k;
			for (int r = 0; r < 12; r++) begin
				x[0] = x[0] ^ MIX_RC[r];
				x = column_sub(x);
				for (int i = 0; i < 8; i++)
					x[i] = diffuse(x[i], 1'b0);
				x = x ^ k;
			end
		end else begin
			for (int r = 11; r >= 0; r--) begin
				x = x ^ k;
				for (int i = 0; i < 8; i++)
					x[i] = diffuse(x[i], 1'b1);
				x = column_unsub(x);
				x[0] = x[0] ^ MIX_RC[r];
			end
			x = x ^ k;
		end
		return x;
	endfunction

	// mostly dense random blocks, some sparse or saturated ones
	function automatic logic [127:0] rand_block();
		logic [127:0] b;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			b = '0;
			b[$urandom_range(0, 127)] = 1'b1;
		end else if (kind == 1) begin
			b = $urandom_range(0, 1) ? {128{1'b1}} : 128'h0;
			b[$urandom_range(0, 127)] = ~b[0];
		end else begin
			b = {$urandom, $urandom, $urandom, $urandom};
		end
		return b;
	endfunction

	// hold start until the item is taken at an edge with busy low
	task automatic issue(input logic cmd, input logic [63:0] lo, input logic [63:0] hi,
	                     input logic [127:0] want);
		logic stalled;
		start <= 1'b1;
		command <= cmd;
		block_low <= lo;
		block_high <= hi;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled !== 1'b0);
		pending_blocks.push_back(want);
		blocks_sent++;
	endtask

	// stop sending and wait until every pending block has come back
	task automatic drain();
		start <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
	endtask

	// both key registers on back-to-back cycles, block idle
	task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
		drain();
		repeat (14) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= fls_pkg::REG_KEY_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cur_key_lo = lo;
		cfg_index <= fls_pkg::REG_KEY_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cur_key_hi = hi;
		cfg_we <= 1'b0;
		key_settings++;
	endtask

	// result checker, sampled mid-cycle
	always @(negedge clk) begin
		logic [127:0] want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected result %h %h", $time, result_high, result_low);
				errors++;
			end else begin
				want = pending_blocks.pop_front();
				if (result_low !== want[63:0]) begin
					$display("%0t: result_low expected %h got %h",
					         $time, want[63:0], result_low);
					errors++;
				end
				if (result_high !== want[127:64]) begin
					$display("%0t: result_high expected %h got %h",
					         $time, want[127:64], result_high);
					errors++;
				end
				blocks_checked++;
			end
			last_lo = result_low;
			last_hi = result_high;
		end
	end

	// stimulus
	initial begin
		logic [127:0] blk;
		logic cmd;
		int left;
		int burst;
		int gap;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= fls_pkg::CMD_ENC;
		block_low <= '0;
		block_high <= '0;
		cfg_we <= 1'b0;
		cfg_index <= fls_pkg::REG_KEY_LOW;
		cfg_data <= '0;
		cur_key_lo = '0;
		cur_key_hi = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed probes under the reset key
		for (int i = 0; i < N_PROBES; i++) begin
			if (PROBES[i].echo) begin
				drain();
				issue(PROBES[i].cmd, last_lo, last_hi, {PROBES[i].hi, PROBES[i].lo});
			end else begin
				issue(PROBES[i].cmd, PROBES[i].lo, PROBES[i].hi,
				      ls_crypt(PROBES[i].cmd, PROBES[i].lo, PROBES[i].hi));
			end
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// random bursts, one key setting per phase
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				1: load_key(ONES, ONES);
				2: load_key({$urandom, $urandom}, {$urandom, $urandom});
				3: load_key(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
				4: load_key({$urandom, $urandom}, {$urandom, $urandom});
				5: load_key(ONES, 64'h0);
				6: load_key(64'h0, 64'h0);
				default: ;
			endcase
			left = PHASE_ITEMS;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				for (int j = 0; j < burst && left > 0; j++) begin
					blk = rand_block();
					cmd = $urandom_range(0, 1) ? fls_pkg::CMD_DEC : fls_pkg::CMD_ENC;
					issue(cmd, blk[63:0], blk[127:64], ls_crypt(cmd, blk[63:0], blk[127:64]));
					left--;
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if ($urandom_range(0, 40) == 0) begin
					drain();
				end else if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d blocks sent, encrypt and decrypt mixed, %0d results checked",
		         blocks_sent, blocks_checked);
		$display("%0d key settings used, including all-zero and all-one keys", key_settings);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
design/fls_pkg.sv
design/fls_round.sv
design/bitsliced_ls_block_cipher.sv
bench/tb.sv
